// ----- rtl/integer_hash_set_macros.svh -----
// ============================================================================
// integer_hash_set_macros
// Assertion macros shared by the hash set RTL. Each use expands to one
// labeled concurrent assertion that reports through $error.
// ============================================================================
`ifndef INTEGER_HASH_SET_MACROS_SVH
`define INTEGER_HASH_SET_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define IHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define IHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ihs_pkg.sv -----
// ============================================================================
// ihs_pkg
// Types and constants of the integer hash set.
// ============================================================================
`default_nettype none

package ihs_pkg;

    localparam int unsigned DEF_BUCKETS = 16;
    localparam int unsigned DEF_WAYS    = 4;

    localparam int unsigned KEY_W       = 32;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned M_TDATA_W   = 16;

    // Result queue depth; a power of two that covers the pipeline round trip.
    localparam int unsigned FIFO_DEPTH  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_CONTAINS = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    // One result, first member in the highest bits.
    typedef struct packed {
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
        logic               bucket_full;
        logic               hit;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/integer_hash_set.sv -----
// A request moves through st1, st2 and st3, then its result is queued for the m_ side.
// Throughput: one request per cycle while m_tready keeps up; a row read-modify-write per
// cycle, with the last written row forwarded to a request that reads the same bucket.
// Reset: pipeline, result queue, element count and per-bucket live bits clear at once;
// the row memory itself is not cleared and no clearing pass is needed.
// ============================================================================
// integer_hash_set
// Bounded set of signed 32-bit integers, stored as BUCKETS rows of WAYS ways.
// ============================================================================
`default_nettype none

`include "integer_hash_set_macros.svh"

module integer_hash_set
    import ihs_pkg::*;
#(
    parameter int unsigned BUCKETS = DEF_BUCKETS,
    parameter int unsigned WAYS    = DEF_WAYS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [KEY_W-1:0]     s_tdata,   // [31:0] value (signed)
    input  wire logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [0] hit, [1] bucket_full,
                                                 // [8:2] entry_count, [9] is_empty
);

    // ------------------------------------------------------------------------
    // Derived sizes.
    // ------------------------------------------------------------------------
    localparam int unsigned BKT_W   = $clog2(BUCKETS);
    localparam int unsigned SLOTS   = BUCKETS * WAYS;
    localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

    // The bucket is found by folding the magnitude into a short byte-weighted
    // sum with the same residue, then reducing that sum with a reciprocal.
    localparam int unsigned SUM_MAX = 255 * (1 + 3 * (BUCKETS - 1));
    localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
    localparam int unsigned C1      = 256 % BUCKETS;
    localparam int unsigned C2      = 65536 % BUCKETS;
    localparam int unsigned C3      = 16777216 % BUCKETS;
    localparam int unsigned RECIP   = (1 << SUM_W) / BUCKETS;

    localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
    localparam int unsigned OCC_W   = PTR_W + 1;
    localparam int unsigned CRD_W   = PTR_W + 2;

    typedef struct packed {
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0][KEY_W-1:0] key;
    } row_t;

    // ------------------------------------------------------------------------
    // Declarations.
    // ------------------------------------------------------------------------
    logic                   accept_c;
    logic [KEY_W-1:0]       mag_c;
    logic [SUM_W-1:0]       sum_c;

    logic                   st1_v_reg, st2_v_reg, st3_v_reg;
    cmd_t                   st1_cmd_reg, st2_cmd_reg, st3_cmd_reg;
    logic [KEY_W-1:0]       st1_key_reg, st2_key_reg, st3_key_reg;
    logic [SUM_W-1:0]       st1_sum_reg, st2_sum_reg;
    logic [SUM_W-1:0]       st2_quo_reg;
    logic [BKT_W-1:0]       st3_bkt_reg;

    logic [2*SUM_W-1:0]     prod_c;
    logic [SUM_W-1:0]       qm_c;
    logic [SUM_W-1:0]       rem_c;
    logic [SUM_W-1:0]       bkt_full_c;
    logic [BKT_W-1:0]       bkt_c;

    row_t                   row_mem [BUCKETS];
    row_t                   rd_row_reg;
    logic [BUCKETS-1:0]     row_live_reg;

    logic                   fwd_valid_reg;
    logic [BKT_W-1:0]       fwd_bkt_reg;
    row_t                   fwd_row_reg;

    row_t                   row_eff_c;
    logic [WAYS-1:0]        vld_eff_c;
    logic [WAYS-1:0]        match_c;
    logic [WAYS-1:0]        free_c;
    logic [WAYS-1:0]        pick_c;
    logic                   found_c;
    logic                   room_c;
    logic                   wr_en_c;
    logic                   clr_c;
    logic                   hit_c;
    logic                   full_c;
    row_t                   row_new_c;
    res_t                   res_c;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    res_t                   res_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic                   pop_c;
    logic [CRD_W-1:0]       credit_c;

    // ------------------------------------------------------------------------
    // Request intake. A request is taken only when the result queue has room
    // for it and for every request still in the pipeline, so the pipeline
    // never has to stall and the memory read data never has to be held.
    // ------------------------------------------------------------------------
    assign credit_c = CRD_W'(occ_reg) + CRD_W'(st1_v_reg) + CRD_W'(st2_v_reg)
                    + CRD_W'(st3_v_reg);
    assign s_tready = (credit_c < CRD_W'(FIFO_DEPTH));
    assign accept_c = s_tvalid && s_tready;

    // Magnitude of the key; the most negative value maps to 2^31 unchanged.
    assign mag_c = s_tdata[KEY_W-1] ? (KEY_W'(0) - s_tdata) : s_tdata;

    // Each byte weighted by 256^i mod BUCKETS keeps the residue of the key.
    assign sum_c = SUM_W'(mag_c[7:0])
                 + SUM_W'(mag_c[15:8])  * SUM_W'(C1)
                 + SUM_W'(mag_c[23:16]) * SUM_W'(C2)
                 + SUM_W'(mag_c[31:24]) * SUM_W'(C3);

    // ------------------------------------------------------------------------
    // Bucket reduction. The reciprocal quotient is at most one below the true
    // quotient, so a single compare and subtract finishes the remainder.
    // ------------------------------------------------------------------------
    assign prod_c     = (2*SUM_W)'(st1_sum_reg) * (2*SUM_W)'(RECIP);
    assign qm_c       = SUM_W'(st2_quo_reg * SUM_W'(BUCKETS));
    assign rem_c      = st2_sum_reg - qm_c;
    assign bkt_full_c = (rem_c >= SUM_W'(BUCKETS)) ? (rem_c - SUM_W'(BUCKETS)) : rem_c;
    assign bkt_c      = bkt_full_c[BKT_W-1:0];

    // ------------------------------------------------------------------------
    // Row memory: one row per bucket, read in the cycle the bucket is known,
    // written back in the next cycle by the execute stage.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en_c) begin
            row_mem[st3_bkt_reg] <= row_new_c;
        end
        rd_row_reg <= row_mem[bkt_c];
    end

    // ------------------------------------------------------------------------
    // Execute stage. The request right behind a write read the memory in the
    // same cycle as that write, so it takes the written row from the forward
    // register instead. A bucket whose live bit is low reads as empty, which
    // is how a clear empties every row without a clearing pass.
    // ------------------------------------------------------------------------
    always_comb begin
        row_eff_c = (fwd_valid_reg && (fwd_bkt_reg == st3_bkt_reg)) ? fwd_row_reg
                                                                     : rd_row_reg;
        vld_eff_c = row_live_reg[st3_bkt_reg] ? row_eff_c.valid : '0;
        for (int w = 0; w < WAYS; w++) begin
            match_c[w] = vld_eff_c[w] && (row_eff_c.key[w] == st3_key_reg);
        end
        found_c = |match_c;
        free_c  = ~vld_eff_c;
        pick_c  = free_c & (~free_c + WAYS'(1));
        room_c  = |free_c;

        wr_en_c         = 1'b0;
        clr_c           = 1'b0;
        hit_c           = 1'b0;
        full_c          = 1'b0;
        count_next      = count_reg;
        row_new_c       = row_eff_c;
        row_new_c.valid = vld_eff_c;

        if (st3_v_reg) begin
            case (st3_cmd_reg)
                CMD_INSERT: begin
                    if (!found_c) begin
                        if (room_c) begin
                            wr_en_c         = 1'b1;
                            hit_c           = 1'b1;
                            row_new_c.valid = vld_eff_c | pick_c;
                            for (int w = 0; w < WAYS; w++) begin
                                if (pick_c[w]) begin
                                    row_new_c.key[w] = st3_key_reg;
                                end
                            end
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            full_c = 1'b1;
                        end
                    end
                end
                CMD_CONTAINS: begin
                    hit_c = found_c;
                end
                CMD_REMOVE: begin
                    if (found_c) begin
                        wr_en_c         = 1'b1;
                        hit_c           = 1'b1;
                        row_new_c.valid = vld_eff_c & ~match_c;
                        count_next      = count_reg - CNT_W'(1);
                    end
                end
                CMD_CLEAR: begin
                    clr_c      = 1'b1;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end

        res_c.hit         = hit_c;
        res_c.bucket_full = full_c;
        res_c.entry_count = COUNT_W'(count_next);
        res_c.is_empty    = (count_next == '0);
    end

    // ------------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------------
    assign m_tvalid = (occ_reg != '0);
    assign m_tdata  = M_TDATA_W'(res_fifo[rd_ptr_reg]);
    assign pop_c    = m_tvalid && m_tready;
    assign occ_next = occ_reg + OCC_W'(st3_v_reg) - OCC_W'(pop_c);

    always_ff @(posedge aclk) begin
        if (st3_v_reg) begin
            res_fifo[wr_ptr_reg] <= res_c;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg     <= 1'b0;
            st2_v_reg     <= 1'b0;
            st3_v_reg     <= 1'b0;
            count_reg     <= '0;
            row_live_reg  <= '0;
            fwd_valid_reg <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            occ_reg       <= '0;
        end else begin
            st1_v_reg     <= accept_c;
            st2_v_reg     <= st1_v_reg;
            st3_v_reg     <= st2_v_reg;
            count_reg     <= count_next;
            fwd_valid_reg <= wr_en_c;
            if (clr_c) begin
                row_live_reg <= '0;
            end else if (wr_en_c) begin
                row_live_reg[st3_bkt_reg] <= 1'b1;
            end
            if (st3_v_reg) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop_c) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            occ_reg <= occ_next;
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline payload registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept_c) begin
            st1_cmd_reg <= cmd_t'(s_tuser);
            st1_key_reg <= s_tdata;
            st1_sum_reg <= sum_c;
        end
        st2_cmd_reg <= st1_cmd_reg;
        st2_key_reg <= st1_key_reg;
        st2_sum_reg <= st1_sum_reg;
        st2_quo_reg <= prod_c[2*SUM_W-1:SUM_W];
        st3_cmd_reg <= st2_cmd_reg;
        st3_key_reg <= st2_key_reg;
        st3_bkt_reg <= bkt_c;
        fwd_bkt_reg <= st3_bkt_reg;
        fwd_row_reg <= row_new_c;
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `IHS_ASSERT_IMPL(a_queue_no_overflow, aclk, aresetn, st3_v_reg && !pop_c, occ_reg < OCC_W'(FIFO_DEPTH), "result queue overflow")
    `IHS_ASSERT_IMPL(a_bucket_in_range, aclk, aresetn, st2_v_reg, bkt_full_c < SUM_W'(BUCKETS), "bucket reduction out of range")
    `IHS_ASSERT_NEXT(a_insert_counts, aclk, aresetn, st3_v_reg && (st3_cmd_reg == CMD_INSERT) && hit_c, count_reg == $past(count_reg) + CNT_W'(1), "insert did not advance the count")
    `IHS_ASSERT_NEXT(a_clear_empties, aclk, aresetn, st3_v_reg && (st3_cmd_reg == CMD_CLEAR), (count_reg == '0) && (row_live_reg == '0), "clear left entries behind")

endmodule

`default_nettype wire
